@@ hdl/lfu_pkg.sv @@
// Shared types and codes for the LFU cache table.
`default_nettype none
package lfu_pkg;
  localparam int FIELD_W = 32;
  localparam int COUNT_W = 32;
  localparam int CAP_W = 5;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic                       mode;
    logic signed [FIELD_W-1:0]  lookup_key;
    logic signed [FIELD_W-1:0]  write_value;
  } in_item_t;

  typedef struct packed {
    logic                       found;
    logic signed [FIELD_W-1:0]  read_value;
    logic                       evicted;
    logic signed [FIELD_W-1:0]  evicted_key;
  } out_item_t;

  typedef struct packed {
    logic                       op;
    logic [FIELD_W-1:0]         key;
    logic [FIELD_W-1:0]         value;
  } req_t;
endpackage
`default_nettype wire

@@ hdl/lfu_cache_table.sv @@
// Top level of the LFU cache table with least-recent tie break.
// Usage:
//   Input channel in_valid/in_ready/in_data carries get (mode 0) or put
//   (mode 1) requests with a key and a value. Result channel
//   out_valid/out_ready/out_data returns one result per request, in order.
//   cfg_wr_en/cfg_wr_data write capacity_in_use; write only while idle.
// Back end:
//   A request passes through the back end in a start step, a scan over
//   every table entry in turn and an update step; a new request is taken
//   only once the last one is through.
//   A two-entry queue sits between intake and back end.
// Reset:
//   rst_n low empties the table and queue and sets capacity to 16.
// Stall:
//   A held result stays in the output register; the back end waits in its
//   update step while further requests collect in the queue until full.
`default_nettype none
module lfu_cache_table
  import lfu_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data,
  input  wire logic             cfg_wr_en,
  input  wire logic [CAP_W-1:0] cfg_wr_data
);
  logic [CAP_W-1:0] cap_r;
  logic             q_valid;
  logic             q_pop;
  req_t             q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_W'(16);
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  lfu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  lfu_back #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cap       (cap_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );
endmodule
`default_nettype wire

@@ hdl/lfu_front.sv @@
// Request intake: classify incoming items and queue them for the back end.
`default_nettype none
module lfu_front
  import lfu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          q_valid,
  output req_t          q_item,
  input  wire logic     q_pop
);
  req_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  req_t       req_nxt;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    req_nxt.op    = in_data.mode ? OP_PUT : OP_GET;
    req_nxt.key   = $unsigned(in_data.lookup_key);
    req_nxt.value = $unsigned(in_data.write_value);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= req_nxt;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      unique case ({push, q_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ hdl/lfu_back.sv @@
// Entry table, scan for hit, free slot and victim, and the table update.
`default_nettype none
module lfu_back
  import lfu_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [CAP_W-1:0] cap,
  input  wire logic             q_valid,
  input  wire req_t             q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data
);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [KEY_BITS-1:0]   key_r   [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] value_r [MAX_ENTRIES];
  logic [COUNT_W-1:0]    count_r [MAX_ENTRIES];
  logic [IDX_W-1:0]      rank_r  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_r;
  logic [OCC_W-1:0]      occ_r;

  logic [1:0]            state_r;
  logic [IDX_W-1:0]      idx_r;
  logic                  op_r;
  logic [KEY_BITS-1:0]   rkey_r;
  logic [VALUE_BITS-1:0] rval_r;

  logic                  hit_f_r, free_f_r, vic_f_r;
  logic [IDX_W-1:0]      hit_idx_r, free_idx_r, vic_idx_r;
  logic [VALUE_BITS-1:0] hit_val_r;
  logic [COUNT_W-1:0]    hit_cnt_r, vic_cnt_r;
  logic [IDX_W-1:0]      hit_rank_r, vic_rank_r;
  logic [KEY_BITS-1:0]   vic_key_r;

  logic                  out_valid_r;
  out_item_t             out_data_r;

  logic [8:0]            cap9, max9, cap_eff, occ9;
  logic                  cap_zero, is_put, use_free, do_touch, do_ins, do_evict;
  logic [IDX_W-1:0]      slot;
  logic                  cur_v, cur_match, vic_better;
  logic                  exec_go;
  out_item_t             res;

  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    cap9     = 9'(cap);
    max9     = 9'(MAX_ENTRIES);
    cap_eff  = (cap9 > max9) ? max9 : cap9;
    occ9     = 9'(occ_r);
    cap_zero = (cap_eff == 9'd0);
    is_put   = (op_r == OP_PUT);
    use_free = (occ9 < cap_eff) && free_f_r;
    do_touch = hit_f_r && (!is_put || !cap_zero);
    do_ins   = is_put && !cap_zero && !hit_f_r && (use_free || vic_f_r);
    do_evict = do_ins && !use_free;
    slot     = use_free ? free_idx_r : vic_idx_r;
    exec_go  = (state_r == ST_EXEC) && (!out_valid_r || out_ready);

    res.found       = hit_f_r;
    res.read_value  = (!is_put && hit_f_r) ? FIELD_W'(hit_val_r) : '0;
    res.evicted     = do_evict;
    res.evicted_key = do_evict ? FIELD_W'(vic_key_r) : '0;

    cur_v      = valid_r[idx_r];
    cur_match  = cur_v && (key_r[idx_r] == rkey_r);
    vic_better = cur_v && (!vic_f_r || (count_r[idx_r] < vic_cnt_r) ||
                 ((count_r[idx_r] == vic_cnt_r) && (rank_r[idx_r] > vic_rank_r)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (exec_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            op_r     <= q_item.op;
            rkey_r   <= KEY_BITS'(q_item.key);
            rval_r   <= VALUE_BITS'(q_item.value);
            idx_r    <= '0;
            hit_f_r  <= 1'b0;
            free_f_r <= 1'b0;
            vic_f_r  <= 1'b0;
            state_r  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cur_match && !hit_f_r) begin
            hit_f_r    <= 1'b1;
            hit_idx_r  <= idx_r;
            hit_val_r  <= value_r[idx_r];
            hit_cnt_r  <= count_r[idx_r];
            hit_rank_r <= rank_r[idx_r];
          end
          if (!cur_v && !free_f_r) begin
            free_f_r   <= 1'b1;
            free_idx_r <= idx_r;
          end
          if (vic_better) begin
            vic_f_r    <= 1'b1;
            vic_idx_r  <= idx_r;
            vic_cnt_r  <= count_r[idx_r];
            vic_rank_r <= rank_r[idx_r];
            vic_key_r  <= key_r[idx_r];
          end
          if (idx_r == IDX_W'(MAX_ENTRIES - 1)) begin
            state_r <= ST_EXEC;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_EXEC: begin
          if (exec_go) begin
            out_data_r  <= res;
            for (int j = 0; j < MAX_ENTRIES; j++) begin
              if ((do_touch && (IDX_W'(j) == hit_idx_r)) ||
                  (do_ins && (IDX_W'(j) == slot))) begin
                rank_r[j] <= '0;
              end else if (valid_r[j] &&
                  ((do_touch && rank_r[j] < hit_rank_r) ||
                   (do_ins && !do_evict) ||
                   (do_evict && rank_r[j] < vic_rank_r))) begin
                rank_r[j] <= rank_r[j] + 1'b1;
              end
            end
            if (do_touch) begin
              if (hit_cnt_r != '1) count_r[hit_idx_r] <= hit_cnt_r + 1'b1;
              if (is_put) value_r[hit_idx_r] <= rval_r;
            end
            if (do_ins) begin
              valid_r[slot] <= 1'b1;
              key_r[slot]   <= rkey_r;
              value_r[slot] <= rval_r;
              count_r[slot] <= COUNT_W'(1);
              if (!do_evict) occ_r <= occ_r + 1'b1;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ hdl/lfu_checker.sv @@
// Port-level checks for the LFU cache table and their binding.
`default_nettype none
module lfu_checker
  import lfu_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_valid)
    else $error("result present after reset");

  a_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.read_value != '0 |-> out_data.found)
    else $error("read value without hit");

  a_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.evicted |-> !out_data.found && out_data.read_value == '0)
    else $error("eviction on a hit");
endmodule

bind lfu_cache_table lfu_checker u_chk (.*);
`default_nettype wire
